FILE: rtl/core/dfspf_pkg.sv
`timescale 1ns / 1ps

package dfspf_pkg;

  // Graph size and the widths that follow from it.
  localparam int MAX_CITIES = 16;
  localparam int NODE_W     = 4;
  localparam int CNT_W      = 5;
  localparam int ROW_W      = MAX_CITIES;

  // Input kinds carried on in_tuser.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Result of the neighbor selection unit.
  typedef struct packed {
    logic              hit;
    logic [NODE_W-1:0] idx;
  } pick_t;

endpackage

FILE: rtl/core/dfspf_nbr_sel.sv
`timescale 1ns / 1ps

module dfspf_nbr_sel (
  input  logic [dfspf_pkg::ROW_W-1:0] row,
  input  logic [dfspf_pkg::ROW_W-1:0] visited,
  input  logic [dfspf_pkg::CNT_W-1:0] cnt_eff,
  output dfspf_pkg::pick_t            pick
);
  import dfspf_pkg::*;

  logic [ROW_W-1:0] cand;

  // Only unvisited neighbors below the active node count are candidates.
  always_comb begin
    for (int i = 0; i < ROW_W; i++) begin
      cand[i] = row[i] && !visited[i] && (CNT_W'(i) < cnt_eff);
    end
  end

  // Priority encoder: the lowest candidate index wins.
  always_comb begin
    pick.hit = |cand;
    pick.idx = '0;
    for (int i = ROW_W - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick.idx = NODE_W'(i);
      end
    end
  end

endmodule

FILE: rtl/core/dfs_path_finder_unit.sv
`timescale 1ns / 1ps

// Depth-first path finder over a directed graph of up to 16 nodes.
// Input stream: in_tuser selects the kind of transfer. A load transfer writes
// one adjacency row (row_index, row_bits) and returns nothing. A query
// transfer (origin_node, target_node) starts a search. The search runs one
// step per cycle on a shared neighbor selection unit (priority encoder): each
// step either pushes the lowest unvisited neighbor of the node on top of the
// stack or pops it. The query then delivers the path, origin first, with tlast
// on the target and tuser (found) high. A failed query, or one naming a node
// at or above city_count, delivers a single transfer with node 0, found low
// and tlast high. The block accepts no input while a query is in progress.
// The result sits in an output register; when the receiver stalls, the path
// delivery waits, and a new item can be accepted once the last result is
// registered. Reset clears the adjacency matrix, sets city_count to 16 and
// empties the output. city_count must be written through cfg_wr_en /
// cfg_wr_data only when idle; the block does not enforce this.
module dfs_path_finder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: city_count.
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_index[3:0], row_bits[19:4],
                                  // origin_node[23:20], target_node[27:24]
  input  logic [0:0]  in_tuser,   // opcode[0]
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // path_node[3:0]
  output logic [0:0]  out_tuser,  // found[0]
  output logic        out_tlast
);
  import dfspf_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SEARCH, ST_EMIT, ST_FAIL} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  city_count_r;
  logic [ROW_W-1:0]  adj_r [MAX_CITIES];
  logic [NODE_W-1:0] stack_mem [MAX_CITIES];
  logic [ROW_W-1:0]  visited_r, visited_nxt;
  logic [CNT_W-1:0]  depth_r, depth_nxt;
  logic [NODE_W-1:0] cur_r, cur_nxt;
  logic [NODE_W-1:0] target_r, target_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [NODE_W-1:0] out_node_r, out_node_nxt;
  logic              out_found_r, out_found_nxt;
  logic              out_last_r, out_last_nxt;

  logic [CNT_W-1:0]  cnt_eff;
  logic              in_xfer;
  logic              out_free;
  logic [NODE_W-1:0] in_row_index;
  logic [ROW_W-1:0]  in_row_bits;
  logic [NODE_W-1:0] in_origin;
  logic [NODE_W-1:0] in_target;
  logic              stk_we;
  logic [NODE_W-1:0] stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic [CNT_W-1:0]  depth_m2;
  pick_t             pick;

  // Field unpacking.
  assign in_row_index = in_tdata[3:0];
  assign in_row_bits  = in_tdata[19:4];
  assign in_origin    = in_tdata[23:20];
  assign in_target    = in_tdata[27:24];

  assign cnt_eff  = (city_count_r > CNT_W'(MAX_CITIES)) ? CNT_W'(MAX_CITIES) : city_count_r;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer  = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;
  assign depth_m2 = depth_r - CNT_W'(2);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      city_count_r <= CNT_W'(MAX_CITIES);
    end else if (cfg_wr_en) begin
      city_count_r <= cfg_wr_data;
    end
  end

  // Adjacency matrix, one row per load transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_CITIES; i++) begin
        adj_r[i] <= '0;
      end
    end else if (in_xfer && in_tuser[0] == OP_LOAD) begin
      adj_r[in_row_index] <= in_row_bits;
    end
  end

  // Shared neighbor selection for the node on top of the stack.
  dfspf_nbr_sel u_nbr_sel (
    .row     (adj_r[cur_r]),
    .visited (visited_r),
    .cnt_eff (cnt_eff),
    .pick    (pick)
  );

  // Path stack: one write port, one read port shared by backtrack and delivery.
  assign stk_raddr = (state_r == ST_EMIT) ? k_r[NODE_W-1:0] : depth_m2[NODE_W-1:0];
  assign stk_rdata = stack_mem[stk_raddr];

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
  end

  // Sequencer: query start, search steps and result delivery.
  always_comb begin
    state_nxt     = state_r;
    visited_nxt   = visited_r;
    depth_nxt     = depth_r;
    cur_nxt       = cur_r;
    target_nxt    = target_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_node_nxt  = out_node_r;
    out_found_nxt = out_found_r;
    out_last_nxt  = out_last_r;
    stk_we        = 1'b0;
    stk_waddr     = '0;
    stk_wdata     = cur_r;

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && in_tuser[0] == OP_QUERY) begin
          target_nxt = in_target;
          if ({1'b0, in_origin} >= cnt_eff || {1'b0, in_target} >= cnt_eff) begin
            state_nxt = ST_FAIL;
          end else begin
            stk_we      = 1'b1;
            stk_waddr   = '0;
            stk_wdata   = in_origin;
            visited_nxt = ROW_W'(1) << in_origin;
            depth_nxt   = CNT_W'(1);
            cur_nxt     = in_origin;
            state_nxt   = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (cur_r == target_r) begin
          k_nxt     = '0;
          state_nxt = ST_EMIT;
        end else if (pick.hit && depth_r < CNT_W'(MAX_CITIES)) begin
          // Descend to the lowest unvisited neighbor.
          stk_we      = 1'b1;
          stk_waddr   = depth_r[NODE_W-1:0];
          stk_wdata   = pick.idx;
          visited_nxt = visited_r | (ROW_W'(1) << pick.idx);
          depth_nxt   = depth_r + CNT_W'(1);
          cur_nxt     = pick.idx;
        end else begin
          // Dead end: backtrack one level.
          depth_nxt = depth_r - CNT_W'(1);
          if (depth_r == CNT_W'(1)) begin
            state_nxt = ST_FAIL;
          end else begin
            cur_nxt = stk_rdata;
          end
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = stk_rdata;
          out_found_nxt = 1'b1;
          out_last_nxt  = (k_r + CNT_W'(1) == depth_r);
          k_nxt         = k_r + CNT_W'(1);
          if (k_r + CNT_W'(1) == depth_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_FAIL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_node_nxt  = '0;
          out_found_nxt = 1'b0;
          out_last_nxt  = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      visited_r   <= '0;
      depth_r     <= '0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      visited_r   <= visited_nxt;
      depth_r     <= depth_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r       <= cur_nxt;
    target_r    <= target_nxt;
    out_node_r  <= out_node_nxt;
    out_found_r <= out_found_nxt;
    out_last_r  <= out_last_nxt;
  end

  // Result outputs.
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_node_r};
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // The stack never grows past MAX_CITIES entries.
  assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(MAX_CITIES))
    else $error("stack depth beyond node count");

  // While searching, the stack is never empty and its top is visited.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> depth_r != '0 && visited_r[cur_r])
    else $error("search step with empty stack or unvisited top");

  // Every stacked node is distinct, so visited covers at least the depth.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> CNT_W'($countones(visited_r)) >= depth_r)
    else $error("visited mask smaller than stack");

  // A selected neighbor is never one already visited.
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH && pick.hit |-> !visited_r[pick.idx])
    else $error("neighbor selection returned a visited node");
`endif

endmodule

FILE: sim/dfs_path_finder_checker.sv
`timescale 1ns / 1ps

module dfs_path_finder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic [0:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic [0:0]  out_tuser,
  input  logic        out_tlast,
  output int          errors,
  output int          pending,
  output int          n_queries,
  output int          n_paths,
  output int          n_misses,
  output int          longest_path,
  output int          n_results
);
  import dfspf_pkg::*;

  localparam int MAX_HOPS = 16;

  // One result transfer as the block should deliver it.
  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              found;
    logic              last;
  } hop_t;

  // Shadow copy of the block's graph, register and search state.
  logic [ROW_W-1:0]      graph_rows [MAX_CITIES];
  logic [CNT_W-1:0]      city_count;
  logic [MAX_CITIES-1:0] seen_mask;
  logic [NODE_W-1:0]     route_stack [MAX_CITIES];
  int unsigned           route_depth;

  // Results still owed by the block, oldest first.
  hop_t route_due[$];

  task automatic report_mismatch(input string what);
    if (errors < 30)
      $display("[%0t] mismatch: %s", $time, what);
    errors++;
  endtask

  // Run the depth-first search on the shadow graph and queue the results.
  task automatic predict_route(input logic [NODE_W-1:0] origin,
                               input logic [NODE_W-1:0] target);
    int unsigned live;
    int unsigned cur;
    int unsigned j;
    int unsigned k;
    int unsigned n;
    bit          pushed;
    bit          reached;
    hop_t        hop;
    live    = (city_count > MAX_CITIES) ? MAX_CITIES : 32'(city_count);
    reached = 1'b0;
    if (origin < live && target < live) begin
      seen_mask         = '0;
      seen_mask[origin] = 1'b1;
      route_stack[0]    = origin;
      route_depth       = 1;
      while (route_depth != 0 && !reached) begin
        cur = 32'(route_stack[route_depth - 1]);
        if (cur == target) begin
          reached = 1'b1;
        end else begin
          // Push the lowest unvisited neighbor, or backtrack.
          pushed = 1'b0;
          for (j = 0; j < live && !pushed; j++) begin
            if (graph_rows[cur][j] && !seen_mask[j] && route_depth < MAX_CITIES) begin
              route_stack[route_depth] = NODE_W'(j);
              route_depth++;
              seen_mask[j] = 1'b1;
              pushed       = 1'b1;
            end
          end
          if (!pushed)
            route_depth--;
        end
      end
    end
    if (reached) begin
      n = (route_depth > MAX_HOPS) ? MAX_HOPS : route_depth;
      for (k = 0; k < n; k++) begin
        hop.node  = route_stack[k];
        hop.found = 1'b1;
        hop.last  = (k + 1 == n);
        route_due.push_back(hop);
      end
      n_paths++;
      if (n > longest_path)
        longest_path = n;
    end else begin
      hop.node  = '0;
      hop.found = 1'b0;
      hop.last  = 1'b1;
      route_due.push_back(hop);
      n_misses++;
    end
  endtask

  // Compare one result transfer with the oldest expectation.
  task automatic check_hop();
    hop_t want;
    if (route_due.size() == 0) begin
      report_mismatch($sformatf("result node %0d found %0d last %0d with nothing expected",
                                out_tdata, out_tuser, out_tlast));
    end else begin
      want = route_due.pop_front();
      if (out_tdata !== {{(8 - NODE_W){1'b0}}, want.node})
        report_mismatch($sformatf("path_node got %0h want %0h", out_tdata, want.node));
      if (out_tuser[0] !== want.found)
        report_mismatch($sformatf("found got %0b want %0b", out_tuser[0], want.found));
      if (out_tlast !== want.last)
        report_mismatch($sformatf("last got %0b want %0b", out_tlast, want.last));
    end
    n_results++;
  endtask

  initial begin
    errors       = 0;
    pending      = 0;
    n_queries    = 0;
    n_paths      = 0;
    n_misses     = 0;
    longest_path = 0;
    n_results    = 0;
  end

  // Follow every transfer and configuration write on the block's ports.
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_CITIES; r++) begin
        graph_rows[r]  = '0;
        route_stack[r] = '0;
      end
      city_count  = 5'd16;
      seen_mask   = '0;
      route_depth = 0;
      route_due.delete();
    end else begin
      // Results go first so that a query accepted at the same edge queues behind them.
      if (out_tvalid && out_tready)
        check_hop();
      if (cfg_wr_en)
        city_count = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        if (in_tuser[0] == OP_LOAD) begin
          graph_rows[in_tdata[3:0]] = in_tdata[19:4];
        end else begin
          predict_route(in_tdata[23:20], in_tdata[27:24]);
          n_queries++;
        end
      end
    end
    pending = route_due.size();
  end

endmodule

FILE: sim/dfs_path_finder_unit_tb.sv
`timescale 1ns / 1ps

module dfs_path_finder_unit_tb;
  import dfspf_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [0:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  int errors;
  int pending;
  int n_queries;
  int n_paths;
  int n_misses;
  int longest_path;
  int n_results;

  int unsigned items_sent = 0;
  int unsigned settings_used = 0;
  bit          no_idle = 1'b0;

  dfs_path_finder_unit i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

  dfs_path_finder_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .out_tlast    (out_tlast),
    .errors       (errors),
    .pending      (pending),
    .n_queries    (n_queries),
    .n_paths      (n_paths),
    .n_misses     (n_misses),
    .longest_path (longest_path),
    .n_results    (n_results)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random unless idling is switched off.
  always @(posedge clk) begin
    out_tready <= no_idle || ($urandom_range(99) >= 35);
  end

  // Present one input item and hold it until the transfer happens.
  // The valid stays high on return so that a following item can reuse it.
  task automatic send_item(input logic op, input logic [3:0] row, input logic [15:0] bits,
                           input logic [3:0] origin, input logic [3:0] target);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0000, target, origin, bits, row};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    items_sent++;
  endtask

  // Unused fields carry random bits; the block must ignore them.
  task automatic send_load(input logic [3:0] row, input logic [15:0] bits);
    send_item(OP_LOAD, row, bits, 4'($urandom_range(15)), 4'($urandom_range(15)));
  endtask

  task automatic send_query(input logic [3:0] origin, input logic [3:0] target);
    send_item(OP_QUERY, 4'($urandom_range(15)), 16'($urandom_range(16'hFFFF)),
              origin, target);
  endtask

  // Write city_count once the block has drained and settled.
  task automatic set_city_count(input logic [4:0] value);
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // Mostly well-formed graphs followed by queries on them, with some noise.
  task automatic random_phase(input logic [4:0] count, input int unsigned budget);
    int unsigned stop_at;
    int unsigned style;
    int unsigned live;
    int unsigned k;
    int unsigned n;
    int unsigned pick;
    int unsigned swap;
    int unsigned order [16];
    logic [15:0] bits;
    logic [15:0] in_range;
    set_city_count(count);
    live     = 32'(count);
    in_range = (live >= 16) ? 16'hFFFF : 16'((32'd1 << live) - 1);
    stop_at  = items_sent + budget;
    while (items_sent < stop_at) begin
      style = $urandom_range(9);
      if (style < 4) begin
        // A chain through every node in use, in shuffled order.
        for (k = 0; k < 16; k++)
          order[k] = k;
        for (k = live - 1; k > 0; k--) begin
          pick        = $urandom_range(k);
          swap        = order[k];
          order[k]    = order[pick];
          order[pick] = swap;
        end
        for (k = 0; k + 1 < live; k++) begin
          bits = 16'(32'd1 << order[k + 1]);
          if ($urandom_range(3) == 0)
            bits |= 16'($urandom_range(16'hFFFF)) & 16'($urandom_range(16'hFFFF)) &
                    16'($urandom_range(16'hFFFF));
          send_load(4'(order[k]), bits);
        end
        // The chain end gets no edges, or only edges beyond the nodes in use.
        bits = $urandom_range(1) ? 16'h0000 : (~in_range & 16'($urandom_range(16'hFFFF)));
        send_load(4'(order[live - 1]), bits);
        send_query(4'(order[0]), 4'(order[live - 1]));
        n = $urandom_range(5, 1);
        for (k = 0; k < n; k++)
          send_query(4'(order[$urandom_range(live - 1)]),
                     4'(order[$urandom_range(live - 1)]));
      end else if (style < 8) begin
        // A few random rows, sparse or dense, then queries.
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++) begin
          bits = 16'($urandom_range(16'hFFFF));
          if ($urandom_range(1))
            bits &= 16'($urandom_range(16'hFFFF));
          send_load(4'($urandom_range(15)), bits);
        end
        n = $urandom_range(5, 1);
        for (k = 0; k < n; k++) begin
          if ($urandom_range(99) < 85)
            send_query(4'($urandom_range(live - 1)), 4'($urandom_range(live - 1)));
          else
            send_query(4'($urandom_range(15)), 4'($urandom_range(15)));
        end
      end else begin
        // Fully random items.
        n = $urandom_range(4, 1);
        for (k = 0; k < n; k++)
          send_item($urandom_range(1) ? OP_QUERY : OP_LOAD, 4'($urandom_range(15)),
                    16'($urandom_range(16'hFFFF)), 4'($urandom_range(15)),
                    4'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    int unsigned drain;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= 5'd0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= OP_LOAD;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty graph, origin equal to target, backtracking, wrap back to node 0.
    send_query(4'd0, 4'd5);
    send_query(4'd7, 4'd7);
    send_query(4'd15, 4'd0);
    send_load(4'd0, 16'hFFFF);
    send_query(4'd0, 4'd15);
    send_load(4'd1, 16'hFFFF);
    send_load(4'd2, 16'hFFFF);
    send_load(4'd3, 16'hFFFF);
    send_query(4'd0, 4'd15);
    send_load(4'd15, 16'h0001);
    send_query(4'd15, 4'd3);
    send_query(4'd4, 4'd0);

    // Smallest graph: only node 0 is valid.
    set_city_count(5'd1);
    send_query(4'd0, 4'd0);
    send_query(4'd0, 4'd1);

    // Edges to nodes beyond city_count are stored but not followed.
    set_city_count(5'd4);
    send_query(4'd0, 4'd3);
    send_query(4'd0, 4'd15);
    send_query(4'd15, 4'd0);
    send_load(4'd15, 16'h0000);
    set_city_count(5'd16);
    send_query(4'd15, 4'd3);

    // Random phases over several graph sizes; one runs without idling.
    random_phase(5'd16, 55);
    random_phase(5'd1, 40);
    random_phase(5'd2, 50);
    random_phase(5'd9, 55);
    no_idle = 1'b1;
    random_phase(5'd16, 60);
    no_idle = 1'b0;
    random_phase(5'd5, 55);
    random_phase(5'd13, 55);
    random_phase(5'd16, 60);

    // Let the last results drain, then settle.
    in_tvalid <= 1'b0;
    @(negedge clk);
    for (drain = 0; pending != 0 && drain < 5000; drain++)
      @(negedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d items (%0d queries) across %0d city_count settings.",
             items_sent, n_queries, settings_used);
    $display("Checked %0d results: %0d paths, longest %0d nodes; %0d queries without a path.",
             n_results, n_paths, longest_path, n_misses);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8_000_000;
    $display("Timeout with %0d results still expected.", pending);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dfspf_pkg.sv
rtl/core/dfspf_nbr_sel.sv
rtl/core/dfs_path_finder_unit.sv
sim/dfs_path_finder_checker.sv
sim/dfs_path_finder_unit_tb.sv
